// ===== rtl/sdsh_pkg.sv =====
`timescale 1ns / 1ps
package sdsh_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_C0, PH_C8, PH_C55, PH_C41, PH_C58, PH_C16, PH_C17, PH_C18, PH_C12, PH_C24,
    PH_IDLEFF, PH_TAIL8, PH_TAIL58, PH_WAITTOK, PH_RDATA, PH_RCRC, PH_WPRE, PH_WTOK,
    PH_WNEED, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY, PH_OK, PH_FAIL, PH_INIT_OK,
    PH_INIT_FAIL
  } phase_t;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_CARD  = 3'd3;
  localparam logic [2:0] OP_WDATA = 3'd4;

  localparam logic [2:0] CFG_RESET_ATT = 3'd0;
  localparam logic [2:0] CFG_READY_ATT = 3'd1;
  localparam logic [2:0] CFG_GAP       = 3'd2;
  localparam logic [2:0] CFG_RESP_WAIT = 3'd3;
  localparam logic [2:0] CFG_TOKEN_TO  = 3'd4;
  localparam logic [2:0] CFG_BUSY_TO   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ERROR     = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  drive;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } in_item_t;

  typedef struct packed {
    logic       exchange;
    logic [7:0] tx_byte;
    logic       chip_select_n;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       need_write_byte;
    logic       done_res;
    logic [1:0] status;
    logic       initialized;
    logic       high_capacity;
  } out_item_t;

endpackage

// ===== rtl/sdsh_stream_if.sv =====
`timescale 1ns / 1ps
interface sdsh_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sd_card_spi_host_sequencer.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_ch   | in  | sdsh_pkg::in_item_t  (request, card byte or write byte)
// out_ch  | out | sdsh_pkg::out_item_t (exchange request, data, done status)
// cfg_    | in  | cfg_we, cfg_index[2:0], cfg_data[19:0]
// Each input beat is handled combinationally by the sequencer; its result lands in the
// output register the next cycle. One beat per cycle is sustained while out_ch drains.
// Input beats that cause no result only update state. rst_n is synchronous, active low.
// A stalled output holds its beat; in_ch.ready is low only while the output register
// is full and not being taken.
module sd_card_spi_host_sequencer #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  sdsh_stream_if.sink   in_ch,
  sdsh_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  localparam int BW = $clog2(BLOCK_BYTES) + 1;

  logic [7:0]  reset_att_r;
  logic [9:0]  ready_att_r;
  logic [15:0] gap_r;
  logic [3:0]  resp_wait_r;
  logic [19:0] token_to_r, busy_to_r;

  sdsh_pkg::phase_t phase_r, phase_nxt, follow_r, follow_nxt;
  logic [BW-1:0] bidx_r, bidx_nxt;
  logic [9:0]  retry_r, retry_nxt;
  logic [19:0] wait_r, wait_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic [47:0] cmd_r, cmd_nxt;
  logic        rdy_r, rdy_nxt, cap_r, cap_nxt, hcs_r, hcs_nxt, multi_r, multi_nxt;
  logic        ov_r;
  sdsh_pkg::out_item_t o_r, o_nxt;
  logic        emit;

  sdsh_pkg::in_item_t it;
  logic acc;
  assign it  = in_ch.payload;
  assign in_ch.ready = !ov_r || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.payload = o_r;

  // Minimum-one forms of the counts.
  logic [7:0]  ra1;
  logic [9:0]  pa1;
  logic [3:0]  rw1;
  logic [19:0] tt1, bt1;
  assign ra1 = (reset_att_r == '0) ? 8'd1 : reset_att_r;
  assign pa1 = (ready_att_r == '0) ? 10'd1 : ready_att_r;
  assign rw1 = (resp_wait_r == '0) ? 4'd1 : resp_wait_r;
  assign tt1 = (token_to_r == '0) ? 20'd1 : token_to_r;
  assign bt1 = (busy_to_r == '0) ? 20'd1 : busy_to_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_att_r <= 8'd20; ready_att_r <= 10'd200; gap_r <= 16'd1000;
      resp_wait_r <= 4'd8; token_to_r <= 20'd100000; busy_to_r <= 20'd500000;
    end else if (cfg_we) begin
      case (cfg_index)
        sdsh_pkg::CFG_RESET_ATT: reset_att_r <= cfg_data[7:0];
        sdsh_pkg::CFG_READY_ATT: ready_att_r <= cfg_data[9:0];
        sdsh_pkg::CFG_GAP:       gap_r <= cfg_data[15:0];
        sdsh_pkg::CFG_RESP_WAIT: resp_wait_r <= cfg_data[3:0];
        sdsh_pkg::CFG_TOKEN_TO:  token_to_r <= cfg_data;
        sdsh_pkg::CFG_BUSY_TO:   busy_to_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state and result for the accepted beat.
  always_comb begin
    sdsh_pkg::phase_t tgt;
    logic doit, idle_go;
    logic [19:0] idle_n;
    logic [31:0] arg;
    logic [5:0]  cno;
    logic [7:0]  crc;
    logic [19:0] wc1;
    logic [9:0]  rc1;
    logic [15:0] lm1;
    logic [47:0] sh;
    phase_nxt = phase_r; follow_nxt = follow_r; bidx_nxt = bidx_r; retry_nxt = retry_r;
    wait_nxt = wait_r; addr_nxt = addr_r; left_nxt = left_r; cmd_nxt = cmd_r;
    rdy_nxt = rdy_r; cap_nxt = cap_r; hcs_nxt = hcs_r; multi_nxt = multi_r;
    o_nxt = '0; emit = 1'b0;
    tgt = sdsh_pkg::PH_IDLE; doit = 1'b0; idle_go = 1'b0; idle_n = 20'd1;
    wc1 = wait_r + 20'd1; rc1 = retry_r + 10'd1; lm1 = left_r - 16'd1;
    arg = '0; cno = '0; crc = 8'hFF; sh = '0;
    if (acc) begin
      case (it.operation)
        sdsh_pkg::OP_INIT, sdsh_pkg::OP_READ, sdsh_pkg::OP_WRITE: begin
          if (phase_r == sdsh_pkg::PH_IDLE) begin
            emit = 1'b1;
            if (it.drive != 8'd0 || (it.operation != sdsh_pkg::OP_INIT && !rdy_r)) begin
              o_nxt.done_res = 1'b1; o_nxt.status = sdsh_pkg::ST_NOT_READY;
            end else if (it.operation == sdsh_pkg::OP_INIT) begin
              retry_nxt = '0; idle_go = 1'b1; idle_n = 20'd10; tgt = sdsh_pkg::PH_C0;
            end else if (it.block_count == 16'd0) begin
              o_nxt.done_res = 1'b1; o_nxt.status = sdsh_pkg::ST_OK;
            end else begin
              addr_nxt = cap_r ? it.sector : {it.sector[22:0], 9'd0};
              left_nxt = it.block_count;
              multi_nxt = it.block_count != 16'd1;
              doit = 1'b1;
              if (it.operation == sdsh_pkg::OP_READ)
                tgt = multi_nxt ? sdsh_pkg::PH_C18 : sdsh_pkg::PH_C17;
              else tgt = sdsh_pkg::PH_C24;
            end
          end
        end
        sdsh_pkg::OP_CARD: begin
          if (phase_r != sdsh_pkg::PH_IDLE && phase_r != sdsh_pkg::PH_WNEED) begin
            emit = 1'b1;
            case (phase_r) inside
              [sdsh_pkg::PH_C0:sdsh_pkg::PH_C24]: begin
                if (bidx_r < BW'(6)) bidx_nxt = bidx_r + BW'(1);
                else begin
                  wait_nxt = wc1;
                  if (!(it.rx_byte == 8'hFF && wc1 < 20'(rw1))) begin
                    case (phase_r)
                      sdsh_pkg::PH_C0:
                        if (it.rx_byte == 8'h01) begin
                          idle_go = 1'b1; tgt = sdsh_pkg::PH_C8;
                        end else begin
                          retry_nxt = rc1; idle_go = 1'b1;
                          tgt = (rc1 < 10'(reset_att_r)) ? sdsh_pkg::PH_C0
                                                         : sdsh_pkg::PH_INIT_FAIL;
                        end
                      sdsh_pkg::PH_C8: begin
                        retry_nxt = '0;
                        if (it.rx_byte == 8'h01) begin
                          hcs_nxt = 1'b1; doit = 1'b1; tgt = sdsh_pkg::PH_TAIL8;
                        end else begin
                          hcs_nxt = 1'b0; idle_go = 1'b1; tgt = sdsh_pkg::PH_C55;
                        end
                      end
                      sdsh_pkg::PH_C55: begin idle_go = 1'b1; tgt = sdsh_pkg::PH_C41; end
                      sdsh_pkg::PH_C41:
                        if (it.rx_byte == 8'd0) begin
                          idle_go = 1'b1;
                          if (hcs_r) tgt = sdsh_pkg::PH_C58;
                          else begin cap_nxt = 1'b0; tgt = sdsh_pkg::PH_C16; end
                        end else begin
                          retry_nxt = rc1; idle_go = 1'b1;
                          idle_n = 20'(gap_r) + 20'd1;
                          tgt = (rc1 < pa1) ? sdsh_pkg::PH_C55 : sdsh_pkg::PH_INIT_FAIL;
                        end
                      sdsh_pkg::PH_C58: begin doit = 1'b1; tgt = sdsh_pkg::PH_TAIL58; end
                      sdsh_pkg::PH_C16: begin
                        idle_go = 1'b1;
                        tgt = (it.rx_byte == 8'd0) ? sdsh_pkg::PH_INIT_OK
                                                   : sdsh_pkg::PH_INIT_FAIL;
                      end
                      sdsh_pkg::PH_C17, sdsh_pkg::PH_C18: begin
                        doit = 1'b1;
                        tgt = (it.rx_byte != 8'd0) ? sdsh_pkg::PH_FAIL
                                                   : sdsh_pkg::PH_WAITTOK;
                      end
                      sdsh_pkg::PH_C12: begin idle_go = 1'b1; tgt = sdsh_pkg::PH_OK; end
                      default: begin
                        doit = 1'b1;
                        tgt = (it.rx_byte != 8'd0) ? sdsh_pkg::PH_FAIL : sdsh_pkg::PH_WPRE;
                      end
                    endcase
                  end
                end
              end
              sdsh_pkg::PH_IDLEFF: begin
                wait_nxt = wait_r - 20'd1;
                if (wait_nxt == '0) begin doit = 1'b1; tgt = follow_r; end
              end
              sdsh_pkg::PH_TAIL8: begin
                bidx_nxt = bidx_r + BW'(1);
                if (bidx_nxt >= BW'(4)) begin idle_go = 1'b1; tgt = sdsh_pkg::PH_C55; end
              end
              sdsh_pkg::PH_TAIL58: begin
                if (bidx_r == '0) cmd_nxt[15:8] = cmd_r[15:8] | it.rx_byte;
                bidx_nxt = bidx_r + BW'(1);
                if (bidx_nxt >= BW'(4)) begin
                  idle_go = 1'b1;
                  if (cmd_nxt[7:0] != 8'd0) tgt = sdsh_pkg::PH_INIT_FAIL;
                  else begin cap_nxt = cmd_nxt[14]; tgt = sdsh_pkg::PH_INIT_OK; end
                end
              end
              sdsh_pkg::PH_WAITTOK: begin
                if (it.rx_byte == 8'hFE) begin doit = 1'b1; tgt = sdsh_pkg::PH_RDATA; end
                else if (it.rx_byte != 8'hFF) begin doit = 1'b1; tgt = sdsh_pkg::PH_FAIL; end
                else begin
                  wait_nxt = wc1;
                  if (wc1 >= tt1) begin doit = 1'b1; tgt = sdsh_pkg::PH_FAIL; end
                end
              end
              sdsh_pkg::PH_RDATA: begin
                o_nxt.data_valid = 1'b1; o_nxt.data_byte = it.rx_byte;
                bidx_nxt = bidx_r + BW'(1);
                if (bidx_nxt >= BW'(BLOCK_BYTES)) begin doit = 1'b1; tgt = sdsh_pkg::PH_RCRC; end
              end
              sdsh_pkg::PH_RCRC: begin
                bidx_nxt = bidx_r + BW'(1);
                if (bidx_nxt >= BW'(2)) begin
                  left_nxt = lm1;
                  if (multi_r && lm1 != '0) begin doit = 1'b1; tgt = sdsh_pkg::PH_WAITTOK; end
                  else begin
                    idle_go = 1'b1; tgt = multi_r ? sdsh_pkg::PH_C12 : sdsh_pkg::PH_OK;
                  end
                end
              end
              sdsh_pkg::PH_WPRE: begin doit = 1'b1; tgt = sdsh_pkg::PH_WTOK; end
              sdsh_pkg::PH_WTOK: begin bidx_nxt = '0; phase_nxt = sdsh_pkg::PH_WNEED; end
              sdsh_pkg::PH_WDATA: begin
                bidx_nxt = bidx_r + BW'(1);
                if (bidx_nxt >= BW'(BLOCK_BYTES)) begin doit = 1'b1; tgt = sdsh_pkg::PH_WCRC; end
                else phase_nxt = sdsh_pkg::PH_WNEED;
              end
              sdsh_pkg::PH_WCRC: begin
                bidx_nxt = bidx_r + BW'(1);
                if (bidx_nxt >= BW'(2)) begin doit = 1'b1; tgt = sdsh_pkg::PH_WRESP; end
              end
              sdsh_pkg::PH_WRESP: begin
                doit = 1'b1;
                tgt = (it.rx_byte[4:0] != 5'h05) ? sdsh_pkg::PH_FAIL : sdsh_pkg::PH_WBUSY;
              end
              sdsh_pkg::PH_WBUSY: begin
                if (it.rx_byte == 8'hFF) begin
                  addr_nxt = addr_r + (cap_r ? 32'd1 : 32'(BLOCK_BYTES));
                  left_nxt = lm1; idle_go = 1'b1;
                  tgt = (lm1 != '0) ? sdsh_pkg::PH_C24 : sdsh_pkg::PH_OK;
                end else begin
                  wait_nxt = wc1;
                  if (wc1 >= bt1) begin doit = 1'b1; tgt = sdsh_pkg::PH_FAIL; end
                end
              end
              default: ;
            endcase
          end
        end
        sdsh_pkg::OP_WDATA: begin
          if (phase_r == sdsh_pkg::PH_WNEED) begin
            emit = 1'b1; phase_nxt = sdsh_pkg::PH_WDATA;
            o_nxt.exchange = 1'b1; o_nxt.tx_byte = it.wr_byte;
          end
        end
        default: ;
      endcase

      // Idle run of n slots; n is at least one.
      if (idle_go) begin
        phase_nxt = sdsh_pkg::PH_IDLEFF; wait_nxt = idle_n; follow_nxt = tgt;
      end
      // Enter a phase: load a command frame, finish, or clear the counters of another phase.
      if (doit) begin
        case (tgt)
          sdsh_pkg::PH_C0:  begin cno = 6'd0; crc = 8'h95; end
          sdsh_pkg::PH_C8:  begin cno = 6'd8; arg = 32'h1AA; crc = 8'h87; end
          sdsh_pkg::PH_C55: cno = 6'd55;
          sdsh_pkg::PH_C41: begin cno = 6'd41; arg = hcs_nxt ? 32'h40000000 : 32'd0; end
          sdsh_pkg::PH_C58: cno = 6'd58;
          sdsh_pkg::PH_C16: begin cno = 6'd16; arg = 32'(BLOCK_BYTES); end
          sdsh_pkg::PH_C17: begin cno = 6'd17; arg = addr_nxt; end
          sdsh_pkg::PH_C18: begin cno = 6'd18; arg = addr_nxt; end
          sdsh_pkg::PH_C12: cno = 6'd12;
          sdsh_pkg::PH_C24: begin cno = 6'd24; arg = addr_nxt; end
          default: ;
        endcase
        case (tgt) inside
          [sdsh_pkg::PH_C0:sdsh_pkg::PH_C24]: begin
            cmd_nxt = {2'b01, cno, arg, crc}; bidx_nxt = '0; wait_nxt = '0; phase_nxt = tgt;
          end
          sdsh_pkg::PH_OK, sdsh_pkg::PH_FAIL, sdsh_pkg::PH_INIT_OK,
          sdsh_pkg::PH_INIT_FAIL: begin
            o_nxt.done_res = 1'b1;
            o_nxt.status = (tgt == sdsh_pkg::PH_OK || tgt == sdsh_pkg::PH_INIT_OK)
                           ? sdsh_pkg::ST_OK : sdsh_pkg::ST_ERROR;
            if (tgt == sdsh_pkg::PH_INIT_OK) rdy_nxt = 1'b1;
            if (tgt == sdsh_pkg::PH_INIT_FAIL) rdy_nxt = 1'b0;
            phase_nxt = sdsh_pkg::PH_IDLE;
          end
          default: begin phase_nxt = tgt; bidx_nxt = '0; wait_nxt = '0; end
        endcase
        // The response to CMD58 seeds the OCR capture.
        if (phase_r == sdsh_pkg::PH_C58) cmd_nxt = {40'd0, it.rx_byte};
      end

      // Exchange request for the phase now entered.
      if (it.operation != sdsh_pkg::OP_WDATA && phase_nxt != sdsh_pkg::PH_IDLE) begin
        if (phase_nxt == sdsh_pkg::PH_WNEED) o_nxt.need_write_byte = 1'b1;
        else begin
          o_nxt.exchange = 1'b1; o_nxt.tx_byte = 8'hFF;
          if (phase_nxt == sdsh_pkg::PH_IDLEFF) o_nxt.chip_select_n = 1'b1;
          else if (phase_nxt == sdsh_pkg::PH_WTOK) o_nxt.tx_byte = 8'hFE;
          else if (phase_nxt >= sdsh_pkg::PH_C0 && phase_nxt <= sdsh_pkg::PH_C24 &&
                   bidx_nxt < BW'(6)) begin
            sh = cmd_nxt << {bidx_nxt[2:0], 3'd0};
            o_nxt.tx_byte = sh[47:40];
          end
        end
      end
      o_nxt.initialized = rdy_nxt;
      o_nxt.high_capacity = cap_nxt;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdsh_pkg::PH_IDLE; follow_r <= sdsh_pkg::PH_IDLE;
      bidx_r <= '0; retry_r <= '0; wait_r <= '0; addr_r <= '0; left_r <= '0;
      cmd_r <= '0; rdy_r <= 1'b0; cap_r <= 1'b0; hcs_r <= 1'b0; multi_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; follow_r <= follow_nxt; bidx_r <= bidx_nxt;
      retry_r <= retry_nxt; wait_r <= wait_nxt; addr_r <= addr_nxt; left_r <= left_nxt;
      cmd_r <= cmd_nxt; rdy_r <= rdy_nxt; cap_r <= cap_nxt; hcs_r <= hcs_nxt;
      multi_r <= multi_nxt;
      if (acc && emit) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (acc && emit) o_r <= o_nxt;
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit && o_nxt.done_res) |=> phase_r == sdsh_pkg::PH_IDLE)
    else $error("done without return to idle");
  a_need_wneed: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit && o_nxt.need_write_byte) |=> phase_r == sdsh_pkg::PH_WNEED)
    else $error("write byte asked outside wait phase");
  a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sdsh_pkg::PH_IDLEFF |-> wait_r != '0)
    else $error("idle run with zero count");
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit) |-> $onehot0({o_nxt.exchange, o_nxt.need_write_byte, o_nxt.done_res}))
    else $error("result mixes kinds");
`endif
endmodule
